>>> src/stbp_pkg.sv
`default_nettype none
package stbp_pkg;
    localparam int MAX_ENTRIES_DEF  = 32;
    localparam int SEARCH_STEPS_DEF = 34;
    localparam int WEIGHT_W = 24;
    localparam int ALPHA_W  = 34;
    localparam int QUOT_W   = 32;
    localparam int SUM_W    = 40;
    localparam int DIVD_W   = ALPHA_W + 8;
    localparam logic [ALPHA_W-1:0] BOUND_TOP = ALPHA_W'(64'd1000 << 24);
    localparam logic [SUM_W-1:0]   TARGET    = SUM_W'(64'd2 << 16);
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // datapath commands issued by the controller
    typedef struct packed {
        logic start_run;   // reset bounds
        logic set_mid;     // latch midpoint
        logic sel_upper;   // divide by upper bound instead of midpoint
        logic clr_sum;     // clear accumulator
        logic div_start;   // launch one division
        logic acc_add;     // add soft value to the accumulator
        logic save_mid;    // copy accumulator to mid_sum
        logic save_upper;  // copy accumulator to upper_sum
        logic update;      // move one bound
    } stbp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mid_hit;
    } stbp_stat_t;
endpackage
`default_nettype wire

>>> src/stbp_datapath.sv
`default_nettype none
module stbp_datapath
    import stbp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire stbp_cmd_t           cmd,
    input  wire logic [WEIGHT_W-1:0] threshold,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire logic [WEIGHT_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]    rd_idx,
    output stbp_stat_t               stat,
    output logic [QUOT_W-1:0]        soft_half
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [WEIGHT_W-1:0] mem [MAX_ENTRIES];
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic [ALPHA_W-1:0]  lower_reg, upper_reg, mid_reg;
    logic [SUM_W-1:0]    acc_reg, mid_sum_reg, upper_sum_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [WEIGHT_W:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [WEIGHT_W:0]   rem_sh;
    logic [WEIGHT_W:0]   rem_sub;
    logic [QUOT_W-1:0]   quo_sat, soft_val;
    logic [SUM_W:0]      acc_sum;
    logic [ALPHA_W:0]    bound_sum;
    logic                mid_lo, mid_hi, up_lo, up_hi;

    // weight memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    // one restoring step of (alpha << 8) / weight
    assign rem_sh  = {rem_reg[WEIGHT_W-1:0], quo_reg[DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, rd_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (cmd.div_start) begin
            quo_reg <= {(cmd.sel_upper ? upper_reg : mid_reg), 8'd0};
            rem_reg <= '0;
            cnt_reg <= CNT_W'(DIVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (!rem_sub[WEIGHT_W]) begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    // saturate quotient; zero weight saturates
    assign quo_sat = (rd_data_reg == '0 || quo_reg[DIVD_W-1:QUOT_W] != '0)
                   ? {QUOT_W{1'b1}} : quo_reg[QUOT_W-1:0];
    assign soft_val = (quo_sat > QUOT_W'(threshold)) ? quo_sat - QUOT_W'(threshold) : '0;
    assign soft_half = soft_val >> 1;
    assign acc_sum = {1'b0, acc_reg} + (SUM_W+1)'(soft_val);
    assign bound_sum = {1'b0, lower_reg} + {1'b0, upper_reg};

    assign mid_lo = mid_sum_reg < TARGET;
    assign mid_hi = mid_sum_reg > TARGET;
    assign up_lo  = upper_sum_reg < TARGET;
    assign up_hi  = upper_sum_reg > TARGET;

    // search registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg     <= '0;
            upper_reg     <= BOUND_TOP;
            mid_reg       <= '0;
            acc_reg       <= '0;
            mid_sum_reg   <= '0;
            upper_sum_reg <= '0;
        end else begin
            if (cmd.start_run) begin
                lower_reg     <= '0;
                upper_reg     <= BOUND_TOP;
                mid_reg       <= '0;
                mid_sum_reg   <= '0;
                upper_sum_reg <= '0;
            end
            if (cmd.set_mid) begin
                mid_reg <= bound_sum[ALPHA_W:1];
            end
            if (cmd.clr_sum) begin
                acc_reg <= '0;
            end else if (cmd.acc_add) begin
                acc_reg <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
            end
            if (cmd.save_mid) begin
                mid_sum_reg <= acc_reg;
            end
            if (cmd.save_upper) begin
                upper_sum_reg <= acc_reg;
            end
            if (cmd.update) begin
                if ((mid_lo && up_hi) || (mid_hi && up_lo)) begin
                    lower_reg <= mid_reg;
                end else begin
                    upper_reg <= mid_reg;
                end
            end
        end
    end

    assign stat.div_done = done_reg;
    assign stat.mid_hit  = (mid_sum_reg == TARGET);
endmodule
`default_nettype wire

>>> src/stbp_ctrl.sv
`default_nettype none
module stbp_ctrl
    import stbp_pkg::*;
#(
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int SEARCH_STEPS = SEARCH_STEPS_DEF,
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
    localparam int STEP_W = $clog2(SEARCH_STEPS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_last_weight,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IDX_W-1:0]       m_index,
    output logic                   m_last,
    output logic                   out_load,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_idx,
    output logic [IDX_W-1:0]       rd_idx,
    output stbp_cmd_t              cmd,
    input  wire stbp_stat_t        stat
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_STEP, ST_READ, ST_DIV, ST_WAIT, ST_SUMEND, ST_CHECK,
        ST_UPDATE, ST_OREAD, ST_ODIV, ST_OWAIT, ST_OEMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               pass_reg;   // 0: midpoint pass, 1: upper pass
    logic               mvalid_reg, mlast_reg;
    logic [IDX_W-1:0]   mindex_reg;
    logic               accept, full, idx_last, out_free;

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign wr_en    = accept && !full;
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign rd_idx   = idx_reg;
    assign idx_last = ({1'b0, idx_reg} == (IDX_W+1)'(count_reg - CNT_W'(1)));
    assign out_free = !mvalid_reg || m_ready;
    assign m_valid  = mvalid_reg;
    assign m_index  = mindex_reg;
    assign m_last   = mlast_reg;
    assign out_load = (state_reg == ST_OEMIT) && out_free;

    // command decode
    always_comb begin
        cmd = '0;
        cmd.sel_upper = pass_reg;
        unique case (state_reg)
            ST_LOAD:   cmd.start_run = accept && s_last_weight;
            ST_STEP:   begin cmd.set_mid = !pass_reg; cmd.clr_sum = 1'b1; end
            ST_DIV:    cmd.div_start = 1'b1;
            ST_WAIT:   cmd.acc_add = stat.div_done;
            ST_SUMEND: begin cmd.save_mid = !pass_reg; cmd.save_upper = pass_reg; end
            ST_UPDATE: cmd.update = 1'b1;
            ST_ODIV:   cmd.div_start = 1'b1;
            default:   ;
        endcase
    end

    // sequence the search and the result pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            idx_reg    <= '0;
            step_reg   <= '0;
            pass_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            mlast_reg  <= 1'b0;
            mindex_reg <= '0;
        end else begin
            if (mvalid_reg && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (!full) count_reg <= count_reg + CNT_W'(1);
                        if (s_last_weight) begin
                            step_reg  <= '0;
                            pass_reg  <= 1'b0;
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_STEP: begin
                    idx_reg   <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ:   state_reg <= ST_DIV;
                ST_DIV:    state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (stat.div_done) begin
                        if (idx_last) begin
                            state_reg <= ST_SUMEND;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_SUMEND: state_reg <= pass_reg ? ST_UPDATE : ST_CHECK;
                ST_CHECK: begin
                    if (stat.mid_hit) begin
                        idx_reg   <= '0;
                        state_reg <= ST_OREAD;
                    end else begin
                        pass_reg  <= 1'b1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_UPDATE: begin
                    pass_reg <= 1'b0;
                    if (step_reg == STEP_W'(SEARCH_STEPS - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= ST_OREAD;
                    end else begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_STEP;
                    end
                end
                ST_OREAD:  state_reg <= ST_ODIV;
                ST_ODIV:   state_reg <= ST_OWAIT;
                ST_OWAIT:  if (stat.div_done) state_reg <= ST_OEMIT;
                ST_OEMIT: begin
                    if (out_free) begin
                        mvalid_reg <= 1'b1;
                        mindex_reg <= idx_reg;
                        mlast_reg  <= idx_last;
                        if (idx_last) begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_OREAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/soft_threshold_bisection_projection.sv
// Search: a set of N weights is searched in up to 2*SEARCH_STEPS passes of
//   N divisions each (42-step restoring divider); then each of the N results
//   takes one more division and may wait on an output stall.
// Throughput: one weight per cycle while loading; a new set is taken once the
//   last result of the previous run sits in the output register.
// Reset: synchronous active-low aresetn clears control, bounds, sums and threshold.
`default_nettype none
module soft_threshold_bisection_projection
    import stbp_pkg::*;
#(
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int SEARCH_STEPS = SEARCH_STEPS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [WEIGHT_W-1:0] cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    input  wire logic                s_last_weight,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [QUOT_W-1:0]        m_projected_value,
    output logic [4:0]               m_entry_index,
    output logic                     m_last_result
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [WEIGHT_W-1:0] thr_reg;
    logic [QUOT_W-1:0]   value_reg;
    logic [QUOT_W-1:0]   soft_half;
    logic [IDX_W-1:0]    m_index, wr_idx, rd_idx;
    logic                wr_en, out_load;
    stbp_cmd_t           cmd;
    stbp_stat_t          stat;

    // hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // capture result value
    always_ff @(posedge aclk) begin
        if (out_load) begin
            value_reg <= soft_half;
        end
    end

    stbp_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .SEARCH_STEPS(SEARCH_STEPS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_last_weight,
        .m_valid, .m_ready, .m_index, .m_last(m_last_result), .out_load,
        .wr_en, .wr_idx, .rd_idx, .cmd, .stat
    );

    stbp_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk, .aresetn, .cmd, .threshold(thr_reg), .wr_en, .wr_idx,
        .wr_data(s_weight), .rd_idx, .stat, .soft_half
    );

    assign m_projected_value = value_reg;
    assign m_entry_index     = 5'(m_index);

    // hold a stalled result transaction unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_projected_value)
            && $stable(m_entry_index) && $stable(m_last_result))
        else $error("result changed while stalled");
    // a division never completes in back-to-back cycles
    assert property (@(posedge aclk) disable iff (!aresetn) stat.div_done |=> !stat.div_done)
        else $error("divider done twice");
    // a bound update never coincides with a load
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.update |-> !s_ready)
        else $error("update while loading");
endmodule
`default_nettype wire

>>> sim/soft_threshold_bisection_projection_tb.sv
`default_nettype none
module soft_threshold_bisection_projection_tb;
    import stbp_pkg::*;

    localparam int STORE_DEPTH  = MAX_ENTRIES_DEF;
    localparam int BISECT_STEPS = SEARCH_STEPS_DEF;
    localparam int HOLD_CYCLES  = 15000;
    localparam int SETTLE       = 200;

    typedef enum logic {ROW_CFG, ROW_WEIGHT} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [WEIGHT_W-1:0]    data;
        logic                   last;
        logic                   typed;
        logic [QUOT_W-1:0]      typed_val;
    } stim_row_t;

    typedef struct {
        logic [QUOT_W-1:0] value;
        logic [4:0]        index;
        logic              last;
    } projection_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [WEIGHT_W-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [WEIGHT_W-1:0] s_weight;
    logic                s_last_weight;
    logic                m_valid;
    logic                m_ready;
    logic [QUOT_W-1:0]   m_projected_value;
    logic [4:0]          m_entry_index;
    logic                m_last_result;

    // predictor state
    logic [WEIGHT_W-1:0] model_threshold;
    logic [WEIGHT_W-1:0] model_weights [STORE_DEPTH];
    int                  model_count;
    projection_t         pending_q [$];
    int                  errors;
    bit                  hold_req;

    soft_threshold_bisection_projection dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_weight          (s_weight),
        .s_last_weight     (s_last_weight),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_projected_value (m_projected_value),
        .m_entry_index     (m_entry_index),
        .m_last_result     (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #16_000_000;
        $display("soft_threshold_bisection_projection_tb NOT OK");
        $finish;
    end

    // soft-thresholded quotient alpha/D in Q16.16
    function automatic logic [63:0] shrunk_quotient(logic [63:0] alpha, logic [WEIGHT_W-1:0] w);
        logic [63:0] q;
        if (w == '0) q = 64'hFFFF_FFFF;
        else q = (alpha << 8) / w;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        return (q > model_threshold) ? q - model_threshold : 64'd0;
    endfunction

    function automatic logic [63:0] shrunk_sum(logic [63:0] alpha);
        logic [63:0] s;
        s = 0;
        for (int i = 0; i < model_count; i++) begin
            s += shrunk_quotient(alpha, model_weights[i]);
            if (s > SUM_MAX) s = SUM_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] bisect_alpha();
        logic [63:0] lo, hi, mid, mid_s, up_s;
        lo = 0;
        hi = BOUND_TOP;
        mid = 0;
        for (int k = 0; k < BISECT_STEPS; k++) begin
            mid = (lo + hi) >> 1;
            mid_s = shrunk_sum(mid);
            if (mid_s == TARGET) break;
            up_s = shrunk_sum(hi);
            if ((mid_s < TARGET && up_s > TARGET) || (mid_s > TARGET && up_s < TARGET))
                lo = mid;
            else
                hi = mid;
        end
        return mid;
    endfunction

    // load one accepted weight; on the last flag queue the projections
    task automatic predict_weight(logic [WEIGHT_W-1:0] w, logic last, logic typed,
                                  logic [QUOT_W-1:0] typed_val);
        logic [63:0] alpha;
        projection_t p;
        if (model_count < STORE_DEPTH) begin
            model_weights[model_count] = w;
            model_count++;
        end
        if (last) begin
            alpha = bisect_alpha();
            for (int i = 0; i < model_count; i++) begin
                p.value = QUOT_W'(shrunk_quotient(alpha, model_weights[i]) >> 1);
                if (typed) p.value = typed_val;
                p.index = 5'(i);
                p.last  = (i + 1 == model_count);
                pending_q.push_back(p);
            end
            model_count = 0;
        end
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_weight(logic [WEIGHT_W-1:0] w, logic last, logic typed = 1'b0,
                               logic [QUOT_W-1:0] typed_val = '0);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_weight      <= w;
        s_last_weight <= last;
        do @(posedge aclk); while (!s_ready);
        predict_weight(w, last, typed, typed_val);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        wait (pending_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [WEIGHT_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        model_threshold = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: throttle by mode, with one long hold-off on request
    initial begin
        int mode;
        int left;
        m_ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 9) < 3);
                end
            endcase
        end
    end

    // compare each result transaction with the oldest projection
    always @(posedge aclk) begin
        projection_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result value=%h index=%0d last=%b", $time,
                         m_projected_value, m_entry_index, m_last_result);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_projected_value !== e.value) begin
                    $display("%0t: projected_value expected %h actual %h", $time,
                             e.value, m_projected_value);
                    errors++;
                end
                if (m_entry_index !== e.index) begin
                    $display("%0t: entry_index expected %0d actual %0d", $time,
                             e.index, m_entry_index);
                    errors++;
                end
                if (m_last_result !== e.last) begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             e.last, m_last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t table_rows [$];
        int burst;
        int set_len;
        int set_no;
        logic [WEIGHT_W-1:0] w;
        errors          = 0;
        hold_req        = 1'b0;
        model_threshold = '0;
        model_count     = 0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_weight        = '0;
        s_last_weight   = 1'b0;
        aresetn         = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero weight saturates, extremes of weight and threshold
        table_rows = '{
            '{ROW_WEIGHT, 24'h000000, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{ROW_WEIGHT, 24'h000001, 1'b1, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'hFFFFFF, 1'b1, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h000001, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h010000, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'hFFFFFF, 1'b1, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h555555, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'hAAAAAA, 1'b1, 1'b0, 32'h0},
            '{ROW_CFG,    24'hFFFFFF, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'hFFFFFF, 1'b1, 1'b1, 32'h0},
            '{ROW_WEIGHT, 24'h000001, 1'b1, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h000000, 1'b1, 1'b1, 32'h7F80_0000},
            '{ROW_CFG,    24'h008000, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h008000, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h020000, 1'b0, 1'b0, 32'h0},
            '{ROW_WEIGHT, 24'h100000, 1'b1, 1'b0, 32'h0}
        };
        foreach (table_rows[i]) begin
            if (table_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_threshold(table_rows[i].data);
            end else begin
                send_weight(table_rows[i].data, table_rows[i].last,
                            table_rows[i].typed, table_rows[i].typed_val);
            end
        end
        wait_drained();
        write_threshold('0);

        // random sets: mostly short, a full store and an overfull one
        burst = 0;
        for (set_no = 0; set_no < 42; set_no++) begin
            if (set_no == 18 || set_no == 36) begin
                wait_drained();
                write_threshold(set_no == 18 ? 24'($urandom_range(0, 24'h03FFFF))
                                             : 24'($urandom));
            end
            if (set_no == 26) wait_drained();
            if (set_no == 9) set_len = STORE_DEPTH;
            else if (set_no == 40) set_len = STORE_DEPTH + 1;
            else if (set_no == 12) set_len = 1;
            else if ($urandom_range(0, 9) == 0) set_len = $urandom_range(4, 8);
            else set_len = $urandom_range(1, 3);
            for (int k = 0; k < set_len; k++) begin
                if (burst == 0) begin
                    idle_sender($urandom_range(0, 6));
                    burst = $urandom_range(1, 10);
                end
                burst--;
                case ($urandom_range(0, 3))
                    0: w = 24'($urandom);
                    1: w = 24'($urandom_range(1, 24'h00FFFF));
                    2: w = 24'($urandom_range(24'h008000, 24'h080000));
                    default: w = 24'($urandom) | 24'h1;
                endcase
                send_weight(w, k == set_len - 1);
            end
            // results of the short set back up while the next set is offered
            if (set_no == 12) hold_req = 1'b1;
        end

        idle_sender(1);
        wait (pending_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("soft_threshold_bisection_projection_tb OK");
        end else begin
            $display("soft_threshold_bisection_projection_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> soft_threshold_bisection_projection.f
src/stbp_pkg.sv
src/stbp_datapath.sv
src/stbp_ctrl.sv
src/soft_threshold_bisection_projection.sv
sim/soft_threshold_bisection_projection_tb.sv
